@@ rtl/core/kpvt_pkg.sv @@
// Package for the constant-velocity Kalman tracker.
// Holds fixed-point constants, register indexes and controller/datapath command types.
`timescale 1ns / 1ps
package kpvt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int IO_BITS       = 32;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_QPOS        = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_QVEL        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RMEAS       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_POS   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_VEL   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_VPOS  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_VVEL  = 3'd7;

    // Micro-operations issued by the controller, one per step.
    typedef enum logic [4:0] {
        OP_LOAD   = 5'd0,   // latch measurement
        OP_XP     = 5'd1,   // xp = x + dt*v
        OP_A00    = 5'd2,   // a00 = P11 + dt*P12
        OP_A01    = 5'd3,   // a01 = P12 + dt*P22
        OP_PP00   = 5'd4,   // pp00 = a00 + dt*a01 + qp
        OP_PP11   = 5'd5,   // pp11 = P22 + qv, s = pp00 + r, e = z - xp
        OP_DIV0   = 5'd6,   // k0 = pp00 / s
        OP_DIV1   = 5'd7,   // k1 = a01 / s
        OP_UPOS   = 5'd8,
        OP_UVEL   = 5'd9,
        OP_UP00   = 5'd10,
        OP_UP01   = 5'd11,
        OP_UP11   = 5'd12
    } t_op;

    typedef struct packed {
        logic mul_start;   // start a multiply with operands of op
        logic mul_commit;  // write multiply-based result of op
        logic div_start;
        logic div_commit;
        logic load;
        logic pre;         // do OP_PP11 additions
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } t_stat;

endpackage

@@ rtl/core/kpvt_if.sv @@
// Valid/ready channel interfaces for the tracker.
// Depends on nothing but the widths handed in.
`timescale 1ns / 1ps
interface kpvt_meas_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] measured_pos;
    modport source (output valid, output measured_pos, input ready);
    modport sink   (input valid, input measured_pos, output ready);
endinterface

interface kpvt_est_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] est_pos;
    logic [W-1:0] est_vel;
    modport source (output valid, output est_pos, output est_vel, input ready);
    modport sink   (input valid, input est_pos, input est_vel, output ready);
endinterface

interface kpvt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/kalman_position_velocity_tracker.sv @@
// Top level of the two-state constant-velocity Kalman tracker.
// Depends on kpvt_pkg, the channel interfaces, kpvt_ctrl and kpvt_dp.
`timescale 1ns / 1ps
// One measured position word in, one word each of position and velocity out,
// Q16.16 with the default parameters. The result is offered once the word has
// gone through four multiplies, the additions, two gains one after the other
// from a serial divider producing one quotient bit per cycle (a gain that
// saturates finishes early) and five more multiplies; all nine multiplies use
// one shared multiplier that sums four half-width partial products. One word
// is worked at a time; the next is taken once the previous result has been
// taken. Configuration is accepted only while the block is idle with no result
// waiting.
module kalman_position_velocity_tracker
    import kpvt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    kpvt_cfg_if.sink       i_cfg,
    kpvt_meas_if.sink      i_meas,
    kpvt_est_if.source     o_est
);

    t_cmd  cmd;
    t_stat stat;

    // take configuration only while idle
    assign i_cfg.ready = i_meas.ready;

    kpvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_meas.valid),
        .o_in_ready  (i_meas.ready),
        .o_out_valid (o_est.valid),
        .i_out_ready (o_est.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kpvt_dp #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid && i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_meas      (i_meas.measured_pos),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_est_pos   (o_est.est_pos),
        .o_est_vel   (o_est.est_vel)
    );

    // no new word while a result waits
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_est.valid |-> !i_meas.ready) else $error("accept while result pending");

    // multiplier and divider never finish together
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.mul_done && stat.div_done)) else $error("both units done");

    // an accepted word drops ready next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_meas.valid && i_meas.ready) |=> !i_meas.ready) else $error("ready after accept");

endmodule

@@ rtl/core/kpvt_ctrl.sv @@
// Sequencer of the tracker: steps the datapath through predict, gains and update.
// Depends on kpvt_pkg.
`timescale 1ns / 1ps
module kpvt_ctrl
    import kpvt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_WAIT  = 5'b00100,
        S_OUT   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_out_valid, n_out_valid;

    logic is_div;
    assign is_div = (r_op == OP_DIV0) || (r_op == OP_DIV1);
    logic is_mul;
    assign is_mul = !is_div && (r_op != OP_PP11);

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_op       = OP_XP;
                    n_state    = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_op == OP_PP11) begin
                    o_cmd.pre = 1'b1;
                    n_op      = OP_DIV0;
                end else begin
                    o_cmd.mul_start = is_mul;
                    o_cmd.div_start = is_div;
                    n_state         = S_WAIT;
                end
            end
            S_WAIT: begin
                if (is_div && i_stat.div_done) begin
                    o_cmd.div_commit = 1'b1;
                    n_state          = S_DONE;
                end else if (!is_div && i_stat.mul_done) begin
                    o_cmd.mul_commit = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                // advance to the next operation, or to output after the last one
                if (r_op == OP_UP11) begin
                    n_state = S_OUT;
                end else begin
                    n_op    = t_op'(r_op + 5'd1);
                    n_state = S_ISSUE;
                end
            end
            S_OUT: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/core/kpvt_dp.sv @@
// Datapath of the tracker: state, config registers, shared multiplier, serial divider.
// Depends on kpvt_pkg.
`timescale 1ns / 1ps
module kpvt_dp
    import kpvt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [IO_BITS-1:0]      i_cfg_data,
    input  logic [IO_BITS-1:0]      i_meas,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic [IO_BITS-1:0]      o_est_pos,
    output logic [IO_BITS-1:0]      o_est_vel
);

    localparam int W  = WORD_BITS;
    localparam int MW = 2 * W;
    localparam int HALF = (W + 1) / 2;
    localparam int CW = $clog2(W + FRAC_BITS + 2);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef logic signed [W-1:0] t_w;

    // Saturating add of two words.
    function automatic t_w sadd(input t_w a, input t_w b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) sadd = s[W] ? WMIN : WMAX;
        else sadd = s[W-1:0];
    endfunction

    function automatic t_w ssub(input t_w a, input t_w b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) ssub = s[W] ? WMIN : WMAX;
        else ssub = s[W-1:0];
    endfunction

    // Widen an io-width value, signed or unsigned as sgn selects, into the word with saturation.
    function automatic t_w from_io(input logic [IO_BITS-1:0] v, input logic sgn);
        logic signed [IO_BITS+W:0] x;
        x = sgn ? {{(W+1){v[IO_BITS-1]}}, v} : {{(W+1){1'b0}}, v};
        if (x > $signed({{(IO_BITS+1){1'b0}}, WMAX})) from_io = WMAX;
        else if (x < $signed({{(IO_BITS+1){1'b1}}, WMIN})) from_io = WMIN;
        else from_io = x[W-1:0];
    endfunction

    function automatic logic [IO_BITS-1:0] to_io(input t_w v);
        logic signed [IO_BITS+W:0] x;
        logic signed [IO_BITS+W:0] hi;
        logic signed [IO_BITS+W:0] lo;
        x  = {{(IO_BITS+1){v[W-1]}}, v};
        hi = (IO_BITS+W+1)'((64'sd1 <<< (IO_BITS-1)) - 64'sd1);
        lo = -hi - 1;
        if (x > hi) to_io = {1'b0, {(IO_BITS-1){1'b1}}};
        else if (x < lo) to_io = {1'b1, {(IO_BITS-1){1'b0}}};
        else to_io = x[IO_BITS-1:0];
    endfunction

    // configuration registers
    t_w r_dt, r_qp, r_qv, r_r;
    // filter state
    t_w r_x, r_v, r_p00, r_p01, r_p11;
    // temporaries
    t_w r_z, r_xp, r_a00, r_a01, r_pp00, r_pp11, r_s, r_e, r_k0, r_k1;

    // ---- shared multiplier: magnitudes split into halves, four partial products ----
    logic [W-1:0]    r_ma, r_mb;
    logic            r_mneg;
    logic [MW-1:0]   r_acc;
    logic [2:0]      r_mstep;
    logic            r_mbusy;
    logic            r_mdone;
    t_w              r_mres;
    t_w              mul_a, mul_b;
    logic [HALF-1:0] pa, pb;
    logic [2*HALF-1:0] pprod;
    logic [MW-1:0]   pshift;

    function automatic logic [W-1:0] magof(input t_w v);
        magof = v[W-1] ? W'(-v) : W'(v);
    endfunction

    always_comb begin
        mul_a = r_dt;
        mul_b = r_v;
        case (i_cmd.op)
            OP_XP:   begin mul_a = r_dt; mul_b = r_v;    end
            OP_A00:  begin mul_a = r_dt; mul_b = r_p01;  end
            OP_A01:  begin mul_a = r_dt; mul_b = r_p11;  end
            OP_PP00: begin mul_a = r_dt; mul_b = r_a01;  end
            OP_UPOS: begin mul_a = r_k0; mul_b = r_e;    end
            OP_UVEL: begin mul_a = r_k1; mul_b = r_e;    end
            OP_UP00: begin mul_a = r_k0; mul_b = r_pp00; end
            OP_UP01: begin mul_a = r_k0; mul_b = r_a01;  end
            OP_UP11: begin mul_a = r_k1; mul_b = r_a01;  end
            default: begin mul_a = r_dt; mul_b = r_v;    end
        endcase
    end

    // partial product select
    always_comb begin
        pa = r_mstep[0] ? HALF'(r_ma >> HALF) : HALF'(r_ma);
        pb = r_mstep[1] ? HALF'(r_mb >> HALF) : HALF'(r_mb);
    end
    assign pprod  = pa * pb;
    assign pshift = MW'(pprod) << ((r_mstep[0] ? HALF : 0) + (r_mstep[1] ? HALF : 0));

    // truncation, sign and saturation of the finished magnitude product
    logic [MW-1:0] mq;
    logic          movf;
    t_w            msat;
    always_comb begin
        mq   = r_acc >> FRAC_BITS;
        movf = (mq >> (W - 1)) != '0;
        if (r_mneg) begin
            if (movf && mq != (MW'(1) << (W - 1))) msat = WMIN;
            else msat = t_w'(-mq[W-1:0]);
        end else begin
            msat = movf ? WMAX : t_w'(mq[W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mstep <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (i_cmd.mul_start) begin
                r_ma    <= magof(mul_a);
                r_mb    <= magof(mul_b);
                r_mneg  <= mul_a[W-1] ^ mul_b[W-1];
                r_acc   <= '0;
                r_mstep <= '0;
                r_mbusy <= 1'b1;
            end else if (r_mbusy) begin
                if (r_mstep == 3'd4) begin
                    r_mres  <= msat;
                    r_mdone <= 1'b1;
                    r_mbusy <= 1'b0;
                end else begin
                    r_acc   <= r_acc + pshift;
                    r_mstep <= r_mstep + 3'd1;
                end
            end
        end
    end

    // ---- serial restoring divider, one quotient bit per cycle ----
    localparam int NB = W + FRAC_BITS;
    logic [NB-1:0] r_num;
    logic [W:0]    r_rem;
    logic [W:0]    r_quo;
    logic [W-1:0]  r_den;
    logic          r_dneg, r_dbusy, r_ddone, r_dzero;
    logic [CW-1:0] r_dcnt;
    t_w            r_dres;
    t_w            div_a;
    logic [W:0]    rsh;
    logic [W+1:0]  rdiff;

    assign div_a = (i_cmd.op == OP_DIV1) ? r_a01 : r_pp00;
    assign rsh   = {r_rem[W-1:0], r_num[NB-1]};
    assign rdiff = {1'b0, rsh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_start) begin
                r_num   <= NB'(magof(div_a)) << FRAC_BITS;
                r_den   <= magof(r_s);
                r_dzero <= (r_s == '0);
                r_dneg  <= div_a[W-1] ^ r_s[W-1];
                r_rem   <= '0;
                r_quo   <= '0;
                r_dcnt  <= CW'(NB);
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (r_dcnt == '0 || r_quo[W]) begin
                    // finish: a quotient reaching 2^W means overflow
                    if (r_dzero) r_dres <= '0;
                    else if (r_quo[W]) r_dres <= r_dneg ? WMIN : WMAX;
                    else if (r_dneg) r_dres <= (r_quo[W-1] && r_quo[W-2:0] != '0) ?
                                              WMIN : t_w'(-r_quo[W-1:0]);
                    else r_dres <= r_quo[W-1] ? WMAX : t_w'(r_quo[W-1:0]);
                    r_ddone <= 1'b1;
                    r_dbusy <= 1'b0;
                end else begin
                    r_num  <= r_num << 1;
                    r_dcnt <= r_dcnt - CW'(1);
                    if (!rdiff[W+1]) begin
                        r_rem <= rdiff[W:0];
                        r_quo <= {r_quo[W-1:0], 1'b1};
                    end else begin
                        r_rem <= rsh;
                        r_quo <= {r_quo[W-1:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_stat.mul_done = r_mdone;
    assign o_stat.div_done = r_ddone;

    // ---- register file, state and step results ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt  <= t_w'(6554);
            r_qp  <= t_w'(65536);
            r_qv  <= t_w'(196608);
            r_r   <= t_w'(655360);
            r_x   <= '0;
            r_v   <= from_io(IO_BITS'(1310720), 1'b1);
            r_p00 <= t_w'(327680);
            r_p01 <= '0;
            r_p11 <= t_w'(327680);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TIME_STEP:  r_dt  <= from_io(IO_BITS'(i_cfg_data[16:0]), 1'b0);
                    REG_QPOS:       r_qp  <= from_io(IO_BITS'(i_cfg_data[30:0]), 1'b0);
                    REG_QVEL:       r_qv  <= from_io(IO_BITS'(i_cfg_data[30:0]), 1'b0);
                    REG_RMEAS:      r_r   <= from_io(IO_BITS'(i_cfg_data[30:0]), 1'b0);
                    REG_START_POS:  r_x   <= from_io(i_cfg_data, 1'b1);
                    REG_START_VEL:  r_v   <= from_io(i_cfg_data, 1'b1);
                    REG_START_VPOS: r_p00 <= from_io(IO_BITS'(i_cfg_data[30:0]), 1'b0);
                    REG_START_VVEL: r_p11 <= from_io(IO_BITS'(i_cfg_data[30:0]), 1'b0);
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_z <= from_io(i_meas, 1'b1);
            end
            if (i_cmd.pre) begin
                r_pp11 <= sadd(r_p11, r_qv);
                r_s    <= sadd(r_pp00, r_r);
                r_e    <= ssub(r_z, r_xp);
            end
            if (i_cmd.div_commit) begin
                if (i_cmd.op == OP_DIV1) r_k1 <= r_dres;
                else r_k0 <= r_dres;
            end
            if (i_cmd.mul_commit) begin
                case (i_cmd.op)
                    OP_XP:   r_xp   <= sadd(r_x, r_mres);
                    OP_A00:  r_a00  <= sadd(r_p00, r_mres);
                    OP_A01:  r_a01  <= sadd(r_p01, r_mres);
                    OP_PP00: r_pp00 <= sadd(sadd(r_a00, r_mres), r_qp);
                    OP_UPOS: r_x    <= sadd(r_xp, r_mres);
                    OP_UVEL: r_v    <= sadd(r_v, r_mres);
                    OP_UP00: r_p00  <= ssub(r_pp00, r_mres);
                    OP_UP01: r_p01  <= ssub(r_a01, r_mres);
                    OP_UP11: r_p11  <= ssub(r_pp11, r_mres);
                    default: ;
                endcase
            end
        end
    end

    assign o_est_pos = to_io(r_x);
    assign o_est_vel = to_io(r_v);

endmodule
